[hw/rtl/flp_pkg.sv]
// ----------------------------------------------------------------------------
// flp_pkg
// Types, codes and sizing constants shared by the four-player link core.
// ----------------------------------------------------------------------------
package flp_pkg;

  // sizing
  localparam int RING_BYTES       = 64;
  localparam int PACKET_BYTES     = 4;
  localparam int KEEPALIVE_START  = 60;
  localparam int KEEPALIVE_EXPIRE = 1;
  localparam int SWITCH_REPEATS   = 4;

  // whole packets that fit in the ring
  localparam int RING_PKTS = RING_BYTES / PACKET_BYTES;

  localparam int IDX_W     = (RING_BYTES > 2) ? $clog2(RING_BYTES) : 1;
  localparam int PHASE_W   = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int PKT_W     = $clog2(RING_PKTS + 1);
  localparam int REPEAT_W  = 3;
  localparam int SUB_W     = 3;

  localparam logic [IDX_W-1:0]    IDX_LAST   = IDX_W'(RING_BYTES - 1);
  localparam logic [PHASE_W:0]    PHASE_END  = (PHASE_W + 1)'(PACKET_BYTES);
  localparam logic [PKT_W:0]      PKT_LIMIT  = (PKT_W + 1)'(RING_PKTS);
  localparam logic [REPEAT_W-1:0] REPEAT_END = REPEAT_W'(SWITCH_REPEATS);
  localparam logic [7:0]          KEEP_START = 8'(KEEPALIVE_START);
  localparam logic [7:0]          KEEP_EXPIRE = 8'(KEEPALIVE_EXPIRE);

  // item kinds
  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_TICK     = 3'd1;
  localparam logic [2:0] KIND_REQ_XFER = 3'd2;
  localparam logic [2:0] KIND_REQ_PING = 3'd3;
  localparam logic [2:0] KIND_SET_TX   = 3'd4;
  localparam logic [2:0] KIND_REMOVE   = 3'd5;
  localparam logic [2:0] KIND_DISCARD  = 3'd6;

  // link bytes
  localparam logic [7:0] PING_HEADER  = 8'hFE;
  localparam logic [7:0] START_MARK   = 8'hCC;
  localparam logic [7:0] RESTART_MARK = 8'hFF;
  localparam logic [7:0] START_CMD    = 8'hAA;
  localparam logic [7:0] RESTART_CMD  = 8'hFF;
  localparam logic [7:0] LOST_MAX     = 8'hFF;

  // sub-states
  localparam logic [SUB_W-1:0] SUB_WAIT_HEADER = 3'd0;
  localparam logic [SUB_W-1:0] SUB_STATUS1     = 3'd1;
  localparam logic [SUB_W-1:0] SUB_STATUS2     = 3'd2;
  localparam logic [SUB_W-1:0] SUB_STATUS3     = 3'd3;
  localparam logic [SUB_W-1:0] SUB_SEND_DONE   = 3'd4;
  localparam logic [SUB_W-1:0] SUB_XFER_RUN    = 3'd0;
  localparam logic [SUB_W-1:0] SUB_XFER_ALIGN  = 3'd1;

  // reported mode codes
  localparam logic [1:0] MODE_CODE_PING    = 2'd0;
  localparam logic [1:0] MODE_CODE_START   = 2'd1;
  localparam logic [1:0] MODE_CODE_XFER    = 2'd2;
  localparam logic [1:0] MODE_CODE_RESTART = 2'd3;

  // register indexes
  localparam logic [1:0] REG_RATE    = 2'd0;
  localparam logic [1:0] REG_ACK_ONE = 2'd1;
  localparam logic [1:0] REG_ACK_TWO = 2'd2;
  localparam logic [1:0] REG_SIZE    = 2'd3;

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [3:0] {
    MODE_PING    = 4'b0001,
    MODE_START   = 4'b0010,
    MODE_XFER    = 4'b0100,
    MODE_RESTART = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  reply_byte;
    logic        request_accepted;
    logic [1:0]  mode_now;
    logic [7:0]  player_status;
    logic [6:0]  packets_ready;
    logic        store_strobe;
    logic [5:0]  store_index;
    logic [7:0]  store_byte;
    logic [7:0]  overflow_count;
    logic [15:0] packet_checksum;
  } out_item_t;

  typedef struct packed {
    logic [7:0] rate_reply;
    logic [7:0] ack_one_reply;
    logic [7:0] ack_two_reply;
    logic [7:0] size_reply;
  } cfg_regs_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_PING:    c = MODE_CODE_PING;
      MODE_START:   c = MODE_CODE_START;
      MODE_XFER:    c = MODE_CODE_XFER;
      MODE_RESTART: c = MODE_CODE_RESTART;
      default:      c = MODE_CODE_PING;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/four_player_link_protocol_core.sv]
// ----------------------------------------------------------------------------
// four_player_link_protocol_core
// Slave side of a four-player serial link hub: input register, one-pass
// state update, result register, and the APB reply-byte registers.
// ----------------------------------------------------------------------------
// an accepted transaction is held in the input register, and its result is
//   registered into the output register when the input register moves on
// throughput: one transaction per cycle unless the output stalls; the input
//   register refills in the same cycle the output register takes its content
// reset: synchronous rst_n clears both stages, the link state and the
//   reply registers; the block can accept as soon as reset is released
module four_player_link_protocol_core
  import flp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_regs_t cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r, s1_valid_nxt;
  logic      s1_move;
  logic      in_take;
  out_item_t step_res;
  out_item_t out_item_r;
  logic      out_valid_r, out_valid_nxt;

  flp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage handshake
  assign s1_move       = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall      = s1_valid_r & ~s1_move;
  assign in_take       = in_valid & ~in_stall;
  assign s1_valid_nxt  = in_take | (s1_valid_r & ~s1_move);
  assign out_valid_nxt = s1_move | (out_valid_r & out_stall);

  flp_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_move),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (step_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

[hw/rtl/flp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// flp_cfg_regs
// APB register file holding the four reply bytes of the ping handshake.
// ----------------------------------------------------------------------------
module flp_cfg_regs
  import flp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_regs_t             cfg
);

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = regs_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.rate_reply    <= 8'd1;
      regs_r.ack_one_reply <= 8'd136;
      regs_r.ack_two_reply <= 8'd136;
      regs_r.size_reply    <= 8'd1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RATE:    regs_r.rate_reply    <= pwdata[7:0];
        REG_ACK_ONE: regs_r.ack_one_reply <= pwdata[7:0];
        REG_ACK_TWO: regs_r.ack_two_reply <= pwdata[7:0];
        REG_SIZE:    regs_r.size_reply    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_RATE:    prdata = {24'd0, regs_r.rate_reply};
      REG_ACK_ONE: prdata = {24'd0, regs_r.ack_one_reply};
      REG_ACK_TWO: prdata = {24'd0, regs_r.ack_two_reply};
      REG_SIZE:    prdata = {24'd0, regs_r.size_reply};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/flp_step.sv]
// ----------------------------------------------------------------------------
// flp_step
// Link state registers and the single-pass update for one item. The result
// is formed from the updated state; the state commits when fire is high.
// ----------------------------------------------------------------------------
module flp_step
  import flp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t result
);

  mode_t              mode_r, mode_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [7:0]         status_r, status_nxt;
  logic [REPEAT_W-1:0] repeat_r, repeat_nxt;
  logic               pending_r, pending_nxt;
  logic [7:0]         local_tx_r, local_tx_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [IDX_W-1:0]   widx_r, widx_nxt;
  logic [PKT_W-1:0]   pkts_r, pkts_nxt;
  logic [7:0]         discard_r, discard_nxt;
  logic [7:0]         lost_r, lost_nxt;
  logic [7:0]         keep_r, keep_nxt;
  logic [15:0]        csum_r, csum_nxt;

  logic               back_ping;
  logic               room;
  logic [REPEAT_W-1:0] rep_inc;
  logic [SUB_W-1:0]   sub_inc;
  logic [PHASE_W:0]   phase_inc;
  logic [7:0]         keep_dec;
  logic [7:0]         reply;
  logic               accepted;
  logic               strobe;
  logic [IDX_W-1:0]   sidx;
  logic [7:0]         sbyte;

  assign room      = ((PKT_W + 1)'(pkts_r) + 1'b1) <= PKT_LIMIT;
  assign rep_inc   = repeat_r + 1'b1;
  assign sub_inc   = sub_r + 1'b1;
  assign phase_inc = {1'b0, phase_r} + 1'b1;
  assign keep_dec  = keep_r - 1'b1;

  // next-state logic for one item
  always_comb begin
    mode_nxt     = mode_r;
    sub_nxt      = sub_r;
    status_nxt   = status_r;
    repeat_nxt   = repeat_r;
    pending_nxt  = pending_r;
    local_tx_nxt = local_tx_r;
    phase_nxt    = phase_r;
    widx_nxt     = widx_r;
    pkts_nxt     = pkts_r;
    discard_nxt  = discard_r;
    lost_nxt     = lost_r;
    keep_nxt     = keep_r;
    csum_nxt     = csum_r;
    back_ping    = 1'b0;
    reply        = 8'd0;
    accepted     = 1'b0;
    strobe       = 1'b0;
    sidx         = '0;
    sbyte        = 8'd0;

    case (item.kind)
      KIND_BYTE: begin
        keep_nxt = KEEP_START;
        unique case (mode_r)
          MODE_PING: begin
            if (item.value == PING_HEADER) begin
              sub_nxt = SUB_STATUS1;
              reply   = cfg.ack_one_reply;
            end else if ((item.value == START_MARK) && (rep_inc >= REPEAT_END)) begin
              // run of start marks: enter transfer with an empty buffer
              mode_nxt   = MODE_XFER;
              sub_nxt    = SUB_XFER_RUN;
              repeat_nxt = '0;
              phase_nxt  = '0;
              widx_nxt   = '0;
              pkts_nxt   = '0;
            end else begin
              repeat_nxt = (item.value == START_MARK) ? rep_inc : '0;
              case (sub_r)
                SUB_STATUS1: begin
                  reply      = cfg.ack_two_reply;
                  status_nxt = item.value;
                  sub_nxt    = SUB_STATUS2;
                end
                SUB_STATUS2: begin
                  reply      = cfg.rate_reply;
                  status_nxt = item.value;
                  sub_nxt    = SUB_STATUS3;
                end
                SUB_STATUS3: begin
                  reply      = cfg.size_reply;
                  status_nxt = item.value;
                  sub_nxt    = SUB_WAIT_HEADER;
                  if (pending_r) begin
                    mode_nxt    = MODE_START;
                    pending_nxt = 1'b0;
                  end
                end
                default: ;
              endcase
            end
          end
          MODE_START: begin
            reply = START_CMD;
            if (sub_inc >= SUB_SEND_DONE) begin
              mode_nxt   = MODE_PING;
              sub_nxt    = SUB_WAIT_HEADER;
              repeat_nxt = '0;
            end else begin
              sub_nxt = sub_inc;
            end
          end
          MODE_XFER: begin
            if ((item.value == RESTART_MARK) && (rep_inc >= REPEAT_END)) begin
              back_ping = 1'b1;
            end else begin
              repeat_nxt = (item.value == RESTART_MARK) ? rep_inc : '0;
              // local byte goes out at the first byte of each packet
              if (phase_r == '0) begin
                reply        = local_tx_r;
                local_tx_nxt = 8'd0;
              end
              // store, skip while discarding, or count as lost
              if (room) begin
                if (discard_r == 8'd0) begin
                  strobe   = 1'b1;
                  sidx     = widx_r;
                  sbyte    = item.value;
                  widx_nxt = (widx_r == IDX_LAST) ? '0 : widx_r + 1'b1;
                  csum_nxt = csum_r + {8'd0, item.value};
                end
              end else if (lost_r != LOST_MAX) begin
                lost_nxt = lost_r + 1'b1;
              end
              // packet boundary
              if (phase_inc >= PHASE_END) begin
                phase_nxt = '0;
                if (discard_r != 8'd0) begin
                  discard_nxt = discard_r - 1'b1;
                end else if (room) begin
                  pkts_nxt = pkts_r + 1'b1;
                  csum_nxt = csum_nxt + 16'd1;
                end
                if (sub_r == SUB_XFER_ALIGN) begin
                  mode_nxt = MODE_RESTART;
                  sub_nxt  = SUB_XFER_RUN;
                end
              end else begin
                phase_nxt = phase_inc[PHASE_W-1:0];
              end
            end
          end
          MODE_RESTART: begin
            reply = RESTART_CMD;
            if (sub_inc >= SUB_SEND_DONE) begin
              back_ping = 1'b1;
            end else begin
              sub_nxt = sub_inc;
            end
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (keep_r != 8'd0) begin
          keep_nxt = keep_dec;
          if (keep_dec == KEEP_EXPIRE) begin
            back_ping = 1'b1;
          end
        end
      end
      KIND_REQ_XFER: begin
        if (mode_r == MODE_PING) begin
          pending_nxt = 1'b1;
          accepted    = 1'b1;
        end
      end
      KIND_REQ_PING: begin
        if (mode_r == MODE_XFER) begin
          sub_nxt  = SUB_XFER_ALIGN;
          accepted = 1'b1;
        end
      end
      KIND_SET_TX: begin
        local_tx_nxt = item.value;
      end
      KIND_REMOVE: begin
        // packet counts compare directly since the buffer holds whole packets
        if (9'(item.value) <= 9'(pkts_r)) begin
          pkts_nxt = pkts_r - PKT_W'(item.value);
          accepted = 1'b1;
        end
      end
      KIND_DISCARD: begin
        discard_nxt = item.value;
      end
      default: ;
    endcase

    // return to ping mode
    if (back_ping) begin
      mode_nxt    = MODE_PING;
      sub_nxt     = SUB_WAIT_HEADER;
      status_nxt  = 8'd0;
      repeat_nxt  = '0;
      keep_nxt    = KEEP_START;
      pending_nxt = 1'b0;
      discard_nxt = 8'd0;
      lost_nxt    = 8'd0;
      csum_nxt    = 16'd0;
    end
  end

  // result from the updated state
  always_comb begin
    result.reply_byte       = reply;
    result.request_accepted = accepted;
    result.mode_now         = mode_code(mode_nxt);
    result.player_status    = status_nxt;
    result.packets_ready    = 7'(pkts_nxt);
    result.store_strobe     = strobe;
    result.store_index      = 6'(sidx);
    result.store_byte       = sbyte;
    result.overflow_count   = lost_nxt;
    result.packet_checksum  = csum_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_PING;
      sub_r      <= SUB_WAIT_HEADER;
      status_r   <= 8'd0;
      repeat_r   <= '0;
      pending_r  <= 1'b0;
      local_tx_r <= 8'd0;
      phase_r    <= '0;
      widx_r     <= '0;
      pkts_r     <= '0;
      discard_r  <= 8'd0;
      lost_r     <= 8'd0;
      keep_r     <= KEEP_START;
      csum_r     <= 16'd0;
    end else if (fire) begin
      mode_r     <= mode_nxt;
      sub_r      <= sub_nxt;
      status_r   <= status_nxt;
      repeat_r   <= repeat_nxt;
      pending_r  <= pending_nxt;
      local_tx_r <= local_tx_nxt;
      phase_r    <= phase_nxt;
      widx_r     <= widx_nxt;
      pkts_r     <= pkts_nxt;
      discard_r  <= discard_nxt;
      lost_r     <= lost_nxt;
      keep_r     <= keep_nxt;
      csum_r     <= csum_nxt;
    end
  end

endmodule

[hw/rtl/flp_checker.sv]
// ----------------------------------------------------------------------------
// flp_checker
// Port-level checks on the link core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module flp_checker
  import flp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // store fields are zero without a strobe
  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.store_strobe |->
      out_data.store_index == 6'd0 && out_data.store_byte == 8'd0)
    else $error("store fields set without strobe");

  // stores happen only in transfer mode, or on the packet end that enters
  // restart mode, and never with a request
  a_store_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.store_strobe |->
      (out_data.mode_now == MODE_CODE_XFER || out_data.mode_now == MODE_CODE_RESTART) &&
      !out_data.request_accepted)
    else $error("store outside transfer mode");

  // a reply byte and an accepted request never share one transaction
  a_reply_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.request_accepted |-> out_data.reply_byte == 8'd0)
    else $error("reply byte on a request transaction");

  // buffered packets stay within the ring
  a_pkts_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.packets_ready) <= RING_PKTS)
    else $error("packet count beyond ring size");

endmodule

bind four_player_link_protocol_core flp_checker u_flp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
